// ----- rtl/tcb_pkg.sv -----
// Shared constants, types and address helper for the text console buffer writer.
`default_nettype none

package tcb_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 24;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
  localparam logic [OP_W-1:0] OP_LEFT  = 3'd1;
  localparam logic [OP_W-1:0] OP_RIGHT = 3'd2;
  localparam logic [OP_W-1:0] OP_SETPOS = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;
  localparam logic [OP_W-1:0] OP_READ  = 3'd5;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             scroll;
    logic             wr_cell;
    logic             rd_cell;
    logic             clear;
    logic [ROW_W-1:0] rd_row;
    logic [COL_W-1:0] rd_col;
  } cur_next_t;

  // Map a logical row/column to a memory address; rows rotate by base.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] base);
    logic [ROW_W:0] sum;
    sum = {1'b0, row} + {1'b0, base};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return ADDR_W'(ADDR_W'(sum) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/text_console_buffer_writer.sv -----
// Top level of the text console buffer writer: control, cursor and cell memory.
// A request's result loads into the output register once that is empty or draining,
// and only then is a new request taken; a scroll or a clear runs its fill first.
// A scroll fills a row of 80 cells and a clear all 1920 cells, one cell per cycle.
// Reset clears control state at once, then a fill pass writes spaces
// in attribute 0x07 to every cell; no request is accepted until it ends.
`default_nettype none

module text_console_buffer_writer
  import tcb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration register
  input  wire logic              text_attribute_we_i,
  input  wire logic [ATTR_W-1:0] text_attribute_i,
  // request channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [OP_W-1:0]   opcode_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [ROW_W-1:0]  row_i,
  input  wire logic [COL_W-1:0]  column_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ROW_W-1:0]       cursor_row_out_o,
  output logic [COL_W-1:0]       cursor_col_out_o,
  output logic [CHAR_W-1:0]      read_char_o,
  output logic [ATTR_W-1:0]      read_attr_o,
  output logic                   scrolled_o
);

  typedef enum logic [3:0] {
    ST_INIT = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_FILL = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [ATTR_W-1:0] attr_q;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  // Physical row that holds logical row 0; scrolling rotates it.
  logic [ROW_W-1:0]  base_q, base_d;

  logic [ADDR_W-1:0] fill_addr_q, fill_addr_d;
  logic [ADDR_W-1:0] fill_end_q, fill_end_d;
  logic [ATTR_W-1:0] fill_attr_q, fill_attr_d;

  logic res_read_q, res_read_d;
  logic res_scr_q, res_scr_d;

  logic              out_valid_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic [CHAR_W-1:0] out_char_q;
  logic [ATTR_W-1:0] out_attr_q;
  logic              out_scr_q;

  logic              accept;
  logic              out_load;
  cur_next_t         nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  // Result moves to the output register once it is empty or draining.
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  tcb_cursor u_cursor (
    .opcode_i    (opcode_i),
    .char_code_i (char_code_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .cur_row_i   (cur_row_q),
    .cur_col_i   (cur_col_q),
    .nxt_o       (nxt)
  );

  tcb_ram #(
    .DATA_W (CELL_W),
    .DEPTH  (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request read port: only a read-cell request looks up the memory.
  assign ram_re    = accept && nxt.rd_cell;
  assign ram_raddr = cell_addr(nxt.rd_row, nxt.rd_col, base_q);

  always_comb begin
    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    base_d      = base_q;
    fill_addr_d = fill_addr_q;
    fill_end_d  = fill_end_q;
    fill_attr_d = fill_attr_q;
    res_read_d  = res_read_q;
    res_scr_d   = res_scr_q;
    ram_we      = 1'b0;
    ram_waddr   = fill_addr_q;
    ram_wdata   = {SPACE_CODE, fill_attr_q};

    case (state_q)
      ST_INIT, ST_FILL: begin
        // Sweep spaces over the range, one cell a cycle.
        ram_we = 1'b1;
        if (fill_addr_q == fill_end_q) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          fill_addr_d = fill_addr_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cur_row_d  = nxt.row;
          cur_col_d  = nxt.col;
          res_read_d = nxt.rd_cell;
          res_scr_d  = nxt.scroll;
          fill_attr_d = attr_q;
          if (nxt.wr_cell) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(cur_row_q, cur_col_q, base_q);
            ram_wdata = {char_code_i, attr_q};
          end
          if (nxt.clear) begin
            fill_addr_d = '0;
            fill_end_d  = CELL_LAST;
            state_d     = ST_FILL;
          end else if (nxt.scroll) begin
            // Old top row becomes the new bottom row; rotate and blank it.
            fill_addr_d = cell_addr('0, '0, base_q);
            fill_end_d  = cell_addr('0, COL_LAST, base_q);
            base_d      = (base_q == ROW_LAST) ? '0 : base_q + ROW_W'(1);
            state_d     = ST_FILL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      attr_q      <= RESET_ATTR;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      base_q      <= '0;
      fill_addr_q <= '0;
      fill_end_q  <= CELL_LAST;
      fill_attr_q <= RESET_ATTR;
      res_read_q  <= 1'b0;
      res_scr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      base_q      <= base_d;
      fill_addr_q <= fill_addr_d;
      fill_end_q  <= fill_end_d;
      fill_attr_q <= fill_attr_d;
      res_read_q  <= res_read_d;
      res_scr_q   <= res_scr_d;
      if (text_attribute_we_i) begin
        attr_q <= text_attribute_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload: hold while stalled, load on a finished request.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q  <= cur_row_q;
      out_col_q  <= cur_col_q;
      out_char_q <= res_read_q ? ram_rdata[CELL_W-1:ATTR_W] : '0;
      out_attr_q <= res_read_q ? ram_rdata[ATTR_W-1:0] : '0;
      out_scr_q  <= res_scr_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_row_out_o = out_row_q;
  assign cursor_col_out_o = out_col_q;
  assign read_char_o      = out_char_q;
  assign read_attr_o      = out_attr_q;
  assign scrolled_o       = out_scr_q;

endmodule

`default_nettype wire

// ----- rtl/tcb_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module tcb_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1920
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcb_cursor.sv -----
// Next-cursor decode for one console request.
`default_nettype none

module tcb_cursor
  import tcb_pkg::*;
(
  input  wire logic [OP_W-1:0]   opcode_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [ROW_W-1:0]  row_i,
  input  wire logic [COL_W-1:0]  column_i,
  input  wire logic [ROW_W-1:0]  cur_row_i,
  input  wire logic [COL_W-1:0]  cur_col_i,
  output cur_next_t              nxt_o
);

  logic             adv_wrap;
  logic [ROW_W-1:0] nl_row;
  logic             nl_scroll;
  logic [ROW_W-1:0] clamp_row;
  logic [COL_W-1:0] clamp_col;

  // Start of next row, scroll from the bottom row.
  always_comb begin
    nl_scroll = (cur_row_i == ROW_LAST);
    nl_row    = nl_scroll ? ROW_LAST : cur_row_i + ROW_W'(1);
    adv_wrap  = (cur_col_i == COL_LAST);
    clamp_row = (row_i > ROW_LAST) ? ROW_LAST : row_i;
    clamp_col = (column_i > COL_LAST) ? COL_LAST : column_i;
  end

  always_comb begin
    nxt_o         = '0;
    nxt_o.row     = cur_row_i;
    nxt_o.col     = cur_col_i;
    nxt_o.rd_row  = clamp_row;
    nxt_o.rd_col  = clamp_col;
    case (opcode_i)
      OP_PUT, OP_RIGHT: begin
        if (opcode_i == OP_PUT && char_code_i == NEWLINE_CODE) begin
          nxt_o.row    = nl_row;
          nxt_o.col    = '0;
          nxt_o.scroll = nl_scroll;
        end else begin
          nxt_o.wr_cell = (opcode_i == OP_PUT);
          if (adv_wrap) begin
            nxt_o.row    = nl_row;
            nxt_o.col    = '0;
            nxt_o.scroll = nl_scroll;
          end else begin
            nxt_o.col = cur_col_i + COL_W'(1);
          end
        end
      end
      OP_LEFT: begin
        if (cur_col_i != '0) begin
          nxt_o.col = cur_col_i - COL_W'(1);
        end else if (cur_row_i != '0) begin
          nxt_o.row = cur_row_i - ROW_W'(1);
          nxt_o.col = COL_LAST;
        end
      end
      OP_SETPOS: begin
        nxt_o.row = clamp_row;
        nxt_o.col = clamp_col;
      end
      OP_CLEAR: nxt_o.clear   = 1'b1;
      OP_READ:  nxt_o.rd_cell = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the text console buffer writer: directed and random requests.
module testbench;
  import tcb_pkg::*;

  // Opcodes the block treats as no-ops; it reports the cursor and nothing else.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RESET_CYCLES   = 12;
  // Fills finish before their result is out; give the last result time
  // to leave the output register before touching the attribute.
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 16;
  // Longest correct quiet stretch is the reset fill or a clear plus a stall
  // burst; take several times that.
  localparam int WATCHDOG_LIMIT = 12000;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] rd_char;
    logic [ATTR_W-1:0] rd_attr;
    logic              scrolled;
  } console_result_t;

  logic              clk_i               = 1'b0;
  logic              rst_ni              = 1'b0;
  logic              text_attribute_we_i = 1'b0;
  logic [ATTR_W-1:0] text_attribute_i    = '0;
  logic              in_valid_i          = 1'b0;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i            = '0;
  logic [CHAR_W-1:0] char_code_i         = '0;
  logic [ROW_W-1:0]  row_i               = '0;
  logic [COL_W-1:0]  column_i            = '0;
  logic              out_valid_o;
  logic              out_stall_i         = 1'b0;
  logic [ROW_W-1:0]  cursor_row_out_o;
  logic [COL_W-1:0]  cursor_col_out_o;
  logic [CHAR_W-1:0] read_char_o;
  logic [ATTR_W-1:0] read_attr_o;
  logic              scrolled_o;

  // Shadow copy of the screen, the cursor and the attribute register.
  logic [CHAR_W-1:0] shadow_chars [CELLS];
  logic [ATTR_W-1:0] shadow_attrs [CELLS];
  logic [ROW_W-1:0]  shadow_row;
  logic [COL_W-1:0]  shadow_col;
  logic [ATTR_W-1:0] shadow_text_attr;

  console_result_t pending_results[$];
  int  error_count    = 0;
  int  quiet_cycles   = 0;
  int  stall_left     = 0;
  bit  gaps_enabled   = 1'b1;
  bit  stalls_enabled = 1'b1;

  always #1 clk_i = ~clk_i;

  text_console_buffer_writer dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .text_attribute_we_i (text_attribute_we_i),
    .text_attribute_i    (text_attribute_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .opcode_i            (opcode_i),
    .char_code_i         (char_code_i),
    .row_i               (row_i),
    .column_i            (column_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .cursor_row_out_o    (cursor_row_out_o),
    .cursor_col_out_o    (cursor_col_out_o),
    .read_char_o         (read_char_o),
    .read_attr_o         (read_attr_o),
    .scrolled_o          (scrolled_o)
  );

  // ---------------------------------------------------------------------------
  // Screen predictor
  // ---------------------------------------------------------------------------

  function automatic void fill_screen(input logic [ATTR_W-1:0] attr);
    for (int i = 0; i < CELLS; i++) begin
      shadow_chars[i] = SPACE_CODE;
      shadow_attrs[i] = attr;
    end
  endfunction

  // Move every row up by one and blank the bottom row in the current attribute.
  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) begin
      shadow_chars[i] = shadow_chars[i + COLUMNS];
      shadow_attrs[i] = shadow_attrs[i + COLUMNS];
    end
    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
      shadow_chars[i] = SPACE_CODE;
      shadow_attrs[i] = shadow_text_attr;
    end
  endfunction

  // Go to column 0 of the next row; report whether the screen scrolled.
  function automatic bit move_to_next_row();
    shadow_col = '0;
    if (int'(shadow_row) + 1 >= ROWS) begin
      shadow_row = ROW_LAST;
      scroll_screen();
      return 1'b1;
    end
    shadow_row = shadow_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic bit step_cursor_forward();
    if (int'(shadow_col) + 1 >= COLUMNS) begin
      return move_to_next_row();
    end
    shadow_col = shadow_col + 1'b1;
    return 1'b0;
  endfunction

  function automatic console_result_t predict_console_op(input logic [OP_W-1:0]   op,
                                                         input logic [CHAR_W-1:0] ch,
                                                         input logic [ROW_W-1:0]  r,
                                                         input logic [COL_W-1:0]  c);
    console_result_t res;
    int cell_idx;
    res = '0;
    case (op)
      OP_PUT: begin
        if (ch == NEWLINE_CODE) begin
          res.scrolled = move_to_next_row();
        end else begin
          cell_idx = int'(shadow_row) * COLUMNS + int'(shadow_col);
          if (cell_idx < CELLS) begin
            shadow_chars[cell_idx] = ch;
            shadow_attrs[cell_idx] = shadow_text_attr;
          end
          res.scrolled = step_cursor_forward();
        end
      end
      OP_LEFT: begin
        if (shadow_col != '0) begin
          shadow_col = shadow_col - 1'b1;
        end else if (shadow_row != '0) begin
          shadow_row = shadow_row - 1'b1;
          shadow_col = COL_LAST;
        end
      end
      OP_RIGHT: begin
        res.scrolled = step_cursor_forward();
      end
      OP_SETPOS: begin
        shadow_row = (r > ROW_LAST) ? ROW_LAST : r;
        shadow_col = (c > COL_LAST) ? COL_LAST : c;
      end
      OP_CLEAR: begin
        fill_screen(shadow_text_attr);
      end
      OP_READ: begin
        cell_idx = int'((r > ROW_LAST) ? ROW_LAST : r) * COLUMNS
                 + int'((c > COL_LAST) ? COL_LAST : c);
        res.rd_char = shadow_chars[cell_idx];
        res.rd_attr = shadow_attrs[cell_idx];
      end
      default: begin
      end
    endcase
    res.row = shadow_row;
    res.col = shadow_col;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver, attribute writes and result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Enter right after a rising edge; leave at the edge that takes the request,
  // or after an idle burst that follows it.
  task automatic send_request(input logic [OP_W-1:0]   op,
                              input logic [CHAR_W-1:0] ch,
                              input logic [ROW_W-1:0]  r,
                              input logic [COL_W-1:0]  c);
    int gap;
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    char_code_i <= ch;
    row_i       <= r;
    column_i    <= c;
    // Sample the stall at the falling edge ahead of the taking edge, where it is settled.
    do begin
      @(negedge clk_i);
    end while (in_stall_o !== 1'b0);
    pending_results.push_back(predict_console_op(op, ch, r, c));
    @(posedge clk_i);
    if (gaps_enabled && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop the request valid, drain every result and let the output register empty.
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
    text_attribute_we_i <= 1'b1;
    text_attribute_i    <= value;
    @(posedge clk_i);
    text_attribute_we_i <= 1'b0;
    shadow_text_attr = value;
    @(posedge clk_i);
  endtask

  task automatic check_console_result();
    console_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with no request pending (row %0d col %0d)",
                                cursor_row_out_o, cursor_col_out_o));
      return;
    end
    want = pending_results.pop_front();
    if (cursor_row_out_o !== want.row)
      report_mismatch($sformatf("cursor row got %0d want %0d", cursor_row_out_o, want.row));
    if (cursor_col_out_o !== want.col)
      report_mismatch($sformatf("cursor col got %0d want %0d", cursor_col_out_o, want.col));
    if (read_char_o !== want.rd_char)
      report_mismatch($sformatf("read char got %0h want %0h", read_char_o, want.rd_char));
    if (read_attr_o !== want.rd_attr)
      report_mismatch($sformatf("read attr got %0h want %0h", read_attr_o, want.rd_attr));
    if (scrolled_o !== want.scrolled)
      report_mismatch($sformatf("scrolled got %0b want %0b", scrolled_o, want.scrolled));
  endtask

  // Results are taken at the next rising edge; sample them at the falling one.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      check_console_result();
    end
  end

  // Result-side back-pressure: random bursts of stalled cycles of random length.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_enabled && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // End the run if neither channel moves for too long.
  always @(negedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Read the corners of the freshly filled screen; the second read is clamped.
  task automatic test_reset_contents();
    send_request(OP_READ, 8'h00, 5'd0, 7'd0);
    send_request(OP_READ, 8'hff, 5'h1f, 7'h7f);
    send_request(OP_READ, 8'h00, ROW_LAST, COL_LAST);
  endtask

  // Walk the cursor through every edge case and every opcode.
  task automatic test_cursor_edges();
    send_request(OP_PUT, 8'hff, 5'd0, 7'd0);
    send_request(OP_PUT, 8'h00, 5'd0, 7'd0);
    send_request(OP_PUT, NEWLINE_CODE, 5'd0, 7'd0);
    // wrap back to the last column of the row above
    send_request(OP_LEFT, 8'h00, 5'd0, 7'd0);
    send_request(OP_SETPOS, 8'h00, 5'd0, 7'd0);
    // left at home stays put
    send_request(OP_LEFT, 8'h00, 5'd0, 7'd0);
    send_request(OP_RIGHT, 8'h00, 5'd0, 7'd0);
    send_request(OP_SETPOS, 8'h00, 5'd0, COL_LAST);
    send_request(OP_RIGHT, 8'h00, 5'd0, 7'd0);
    // out-of-range position clamps to the last cell; a put there scrolls
    send_request(OP_SETPOS, 8'h00, 5'h1f, 7'h7f);
    send_request(OP_PUT, 8'h41, 5'd0, 7'd0);
    send_request(OP_SETPOS, 8'h00, ROW_LAST, COL_LAST);
    send_request(OP_RIGHT, 8'h00, 5'd0, 7'd0);
    // newline on the bottom row scrolls as well
    send_request(OP_PUT, NEWLINE_CODE, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, 5'd20, COL_LAST);
    send_request(OP_READ, 8'h00, 5'd0, 7'd0);
    send_request(OP_SPARE_6, 8'hff, 5'h1f, 7'h7f);
    send_request(OP_SPARE_7, 8'h5a, 5'h0a, 7'h2a);
    send_request(OP_SETPOS, 8'h00, 5'd24, 7'd80);
    send_request(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, ROW_LAST, COL_LAST);
  endtask

  // Both attribute extremes, seen through a scroll fill, a clear and a put.
  task automatic test_attribute_extremes();
    wait_for_idle();
    write_text_attribute(8'h00);
    send_request(OP_SETPOS, 8'h00, ROW_LAST, 7'd0);
    send_request(OP_PUT, 8'h7e, 5'd0, 7'd0);
    send_request(OP_PUT, NEWLINE_CODE, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, ROW_LAST, 7'd0);
    send_request(OP_READ, 8'h00, 5'd22, 7'd0);
    wait_for_idle();
    write_text_attribute(8'hff);
    send_request(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_request(OP_PUT, 8'h80, 5'd0, 7'd0);
    send_request(OP_READ, 8'h00, ROW_LAST, 7'd0);
    send_request(OP_READ, 8'h00, 5'd5, 7'd5);
  endtask

  // One random request: mostly text, cursor moves and reads, a rare clear.
  task automatic send_random_request();
    int pick;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  r;
    logic [COL_W-1:0]  c;
    pick = $urandom_range(0, 99);
    ch   = $urandom_range(0, 255);
    r    = $urandom_range(0, 31);
    c    = $urandom_range(0, 127);
    if (pick < 45) begin
      op = OP_PUT;
      if ($urandom_range(0, 11) == 0) ch = NEWLINE_CODE;
    end else if (pick < 55) begin
      op = OP_LEFT;
    end else if (pick < 65) begin
      op = OP_RIGHT;
    end else if (pick < 76) begin
      op = OP_SETPOS;
      // lean toward the bottom right so scrolls come often
      if ($urandom_range(0, 1) == 1) r = $urandom_range(20, 23);
      if ($urandom_range(0, 2) == 0) c = $urandom_range(70, 79);
    end else if (pick < 94) begin
      op = OP_READ;
      if ($urandom_range(0, 4) != 0) begin
        r = $urandom_range(0, ROWS - 1);
        c = $urandom_range(0, COLUMNS - 1);
      end
    end else if (pick < 96) begin
      op = ($urandom_range(0, 1) == 1) ? OP_SPARE_6 : OP_SPARE_7;
    end else if (pick < 97) begin
      op = OP_CLEAR;
    end else begin
      op = OP_PUT;
    end
    send_request(op, ch, r, c);
  endtask

  task automatic test_random_traffic(input int count, input bit gaps, input bit stalls);
    gaps_enabled   = gaps;
    stalls_enabled = stalls;
    repeat (count) send_random_request();
  endtask

  // Close with full-rate traffic: no request gaps and no result stalls.
  task automatic test_back_to_back();
    gaps_enabled   = 1'b0;
    stalls_enabled = 1'b0;
    repeat (150) send_random_request();
  endtask

  initial begin
    fill_screen(RESET_ATTR);
    shadow_row       = '0;
    shadow_col       = '0;
    shadow_text_attr = RESET_ATTR;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_contents();
    test_cursor_edges();
    test_attribute_extremes();
    // Random phases, each under a fresh attribute; one without request gaps
    // and one without result stalls.
    for (int phase = 0; phase < 7; phase++) begin
      wait_for_idle();
      write_text_attribute(ATTR_W'($urandom_range(0, 255)));
      test_random_traffic(240, phase != 3, phase != 5);
    end
    test_back_to_back();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tcb_pkg.sv
rtl/tcb_ram.sv
rtl/tcb_cursor.sv
rtl/text_console_buffer_writer.sv
dv/testbench.sv
